>>> rtl/owe_pkg.sv
// Package for the observer worldline evaluator.
// Holds the item and result payload types and the register index codes.
// No dependencies.
`default_nettype none

package owe_pkg;

    localparam int WORD_W = 32;
    localparam int TOL_W = 16;
    localparam int DT_W = WORD_W + 1;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VELOCITY = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INTERCEPT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REF_TIME = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = 3'd5;

    typedef struct packed {
        logic signed [WORD_W-1:0] coordinate_time;
        logic signed [WORD_W-1:0] event_position;
    } owe_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] observer_position;
        logic signed [WORD_W-1:0] observer_velocity;
        logic                     horizon_valid;
        logic signed [WORD_W-1:0] horizon_position;
        logic                     beyond_horizon;
        logic                     overflow_flag;
    } owe_result_t;

endpackage

`default_nettype wire

>>> rtl/observer_worldline_evaluator.sv
// Observer worldline evaluator, top level: configuration registers and the evaluation pipeline.
// Uses owe_pkg, owe_sqrt and owe_div.
//
// One item is taken on every cycle with start high; busy never rises. Each item gives one
// result, marked by done for one cycle, in order. The path runs through the 64-stage square
// root, the 64-stage divider for q = round(s^2 / (g + 1)) and the 34-stage dividers for
// velocity and position. Results cannot be held off.
`default_nettype none

module observer_worldline_evaluator
    import owe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire owe_item_t            item,
    output logic                      done,
    output owe_result_t               result,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [WORD_W-1:0]    wr_data
);

    localparam int SQ_W  = 128;
    localparam int SQT_W = SQ_W + 64 + DT_W + WORD_W;
    localparam int QT_W  = 64 + 64 + DT_W + WORD_W;
    localparam int RT_W  = DT_W + WORD_W;

    logic                     mode_reg;
    logic signed [WORD_W-1:0] accel_reg;
    logic signed [WORD_W-1:0] velocity_reg;
    logic signed [WORD_W-1:0] intercept_reg;
    logic signed [WORD_W-1:0] ref_time_reg;
    logic [TOL_W-1:0]         tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            accel_reg     <= '0;
            velocity_reg  <= '0;
            intercept_reg <= '0;
            ref_time_reg  <= '0;
            tolerance_reg <= TOL_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MODE:      mode_reg      <= wr_data[0];
                REG_ACCEL:     accel_reg     <= wr_data;
                REG_VELOCITY:  velocity_reg  <= wr_data;
                REG_INTERCEPT: intercept_reg <= wr_data;
                REG_REF_TIME:  ref_time_reg  <= wr_data;
                REG_TOLERANCE: tolerance_reg <= wr_data[TOL_W-1:0];
                default:       ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic [WORD_W-1:0] amag;
    logic [WORD_W-1:0] vmag;
    logic              accelerated;
    logic              horizon_on;

    assign amag = accel_reg[WORD_W-1] ? (~accel_reg + WORD_W'(1)) : accel_reg;
    assign vmag = velocity_reg[WORD_W-1] ? (~velocity_reg + WORD_W'(1)) : velocity_reg;
    assign accelerated = mode_reg && (amag > WORD_W'(tolerance_reg));
    assign horizon_on = accelerated
        && (accel_reg > $signed({{(WORD_W-TOL_W){1'b0}}, tolerance_reg}));

    // reciprocal of |a|, free running off the registers
    logic [DT_W-1:0] inv_quo;

    owe_div #(.NW(DT_W), .DW(WORD_W), .QW(DT_W), .TW(1)) u_inv_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (1'b1),
        .in_num    ({1'b1, WORD_W'(0)} + DT_W'(amag >> 1)),
        .in_den    (amag),
        .in_tag    (1'b0),
        .out_valid (),
        .out_quo   (inv_quo),
        .out_tag   ()
    );

    // stage 1: time offset
    logic                     v1_reg;
    logic signed [DT_W-1:0]   dt1_reg;
    logic signed [WORD_W-1:0] e1_reg;
    logic signed [DT_W-1:0]   dt_next;

    assign dt_next = {item.coordinate_time[WORD_W-1], item.coordinate_time}
                   - {ref_time_reg[WORD_W-1], ref_time_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        dt1_reg <= dt_next;
        e1_reg  <= item.event_position;
    end

    // stage 2: s = |a| * |dt|
    logic                     v2_reg;
    logic [63:0]              s2_reg;
    logic signed [DT_W-1:0]   dt2_reg;
    logic signed [WORD_W-1:0] e2_reg;
    logic [DT_W-1:0]          dmag1;
    logic [64:0]              s_prod;

    assign dmag1  = dt1_reg[DT_W-1] ? (~dt1_reg + DT_W'(1)) : dt1_reg;
    assign s_prod = 65'(amag) * 65'(dmag1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg  <= s_prod[63:0];
        dt2_reg <= dt1_reg;
        e2_reg  <= e1_reg;
    end

    // stage 3: partial products of s * s
    logic                     v3_reg;
    logic [63:0]              pll_reg;
    logic [63:0]              plh_reg;
    logic [63:0]              phh_reg;
    logic [63:0]              s3_reg;
    logic signed [DT_W-1:0]   dt3_reg;
    logic signed [WORD_W-1:0] e3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pll_reg <= 64'(s2_reg[31:0]) * 64'(s2_reg[31:0]);
        plh_reg <= 64'(s2_reg[31:0]) * 64'(s2_reg[63:32]);
        phh_reg <= 64'(s2_reg[63:32]) * 64'(s2_reg[63:32]);
        s3_reg  <= s2_reg;
        dt3_reg <= dt2_reg;
        e3_reg  <= e2_reg;
    end

    // stage 4: s^2 and s^2 + 1.0 in Q64
    logic                     v4_reg;
    logic [SQ_W-1:0]          sq4_reg;
    logic [SQ_W-1:0]          x4_reg;
    logic [63:0]              s4_reg;
    logic signed [DT_W-1:0]   dt4_reg;
    logic signed [WORD_W-1:0] e4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq4_reg <= {phh_reg, 64'd0} + {31'd0, plh_reg, 33'd0} + {64'd0, pll_reg};
        x4_reg  <= {phh_reg, 64'd0} + {31'd0, plh_reg, 33'd0} + {63'd0, 1'b1, pll_reg};
        s4_reg  <= s3_reg;
        dt4_reg <= dt3_reg;
        e4_reg  <= e3_reg;
    end

    // g = floor(sqrt(s^2 + 1))
    logic             sq_valid;
    logic [63:0]      g_root;
    logic [SQT_W-1:0] sq_tag;

    owe_sqrt #(.RW(64), .TW(SQT_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_x      (x4_reg),
        .in_tag    ({sq4_reg, s4_reg, dt4_reg, e4_reg}),
        .out_valid (sq_valid),
        .out_root  (g_root),
        .out_tag   (sq_tag)
    );

    // stage 5: operands for q = round(s^2 / (g + 1))
    logic                     v5_reg;
    logic [SQ_W-1:0]          numq5_reg;
    logic [63:0]              denq5_reg;
    logic [QT_W-1:0]          tag5_reg;
    logic [SQ_W-1:0]          sq5;
    logic [63:0]              s5;
    logic [RT_W-1:0]          de5;

    assign {sq5, s5, de5} = sq_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        numq5_reg <= sq5 + SQ_W'(g_root >> 1) + (SQ_W'(1) << 31);
        denq5_reg <= g_root + (64'd1 << 32);
        tag5_reg  <= {g_root, s5, de5};
    end

    logic            qd_valid;
    logic [63:0]     q_quo;
    logic [QT_W-1:0] qd_tag;

    owe_div #(.NW(SQ_W), .DW(64), .QW(64), .TW(QT_W)) u_q_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_num    (numq5_reg),
        .in_den    (denq5_reg),
        .in_tag    (tag5_reg),
        .out_valid (qd_valid),
        .out_quo   (q_quo),
        .out_tag   (qd_tag)
    );

    // stage 6: operands for position term and velocity
    logic            v6_reg;
    logic [63:0]     numr6_reg;
    logic [93:0]     numv6_reg;
    logic [63:0]     denv6_reg;
    logic [RT_W-1:0] tag6_reg;
    logic [63:0]     g6;
    logic [63:0]     s6;
    logic [RT_W-1:0] de6;

    assign {g6, s6, de6} = qd_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else
        begin
            v6_reg <= qd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        numr6_reg <= q_quo + 64'(amag >> 1);
        numv6_reg <= (94'(s6) << 30) + 94'(g6 >> 1);
        denv6_reg <= g6;
        tag6_reg  <= de6;
    end

    logic            rd_valid;
    logic [33:0]     r_quo;
    logic [RT_W-1:0] rd_tag;
    logic [33:0]     v_quo;

    owe_div #(.NW(64), .DW(WORD_W), .QW(34), .TW(RT_W)) u_r_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .in_num    (numr6_reg),
        .in_den    (amag),
        .in_tag    (tag6_reg),
        .out_valid (rd_valid),
        .out_quo   (r_quo),
        .out_tag   (rd_tag)
    );

    owe_div #(.NW(94), .DW(64), .QW(34), .TW(1)) u_v_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .in_num    (numv6_reg),
        .in_den    (denv6_reg),
        .in_tag    (1'b0),
        .out_valid (),
        .out_quo   (v_quo),
        .out_tag   ()
    );

    // stage 7: inertial product
    logic                     v7_reg;
    logic [30:0]              vm7_reg;
    logic [33:0]              r7_reg;
    logic [64:0]              pv7_reg;
    logic signed [DT_W-1:0]   dt7_reg;
    logic signed [WORD_W-1:0] e7_reg;
    logic signed [DT_W-1:0]   dt6;
    logic signed [WORD_W-1:0] e6;
    logic [DT_W-1:0]          dmag6;

    assign {dt6, e6} = rd_tag;
    assign dmag6 = dt6[DT_W-1] ? (~dt6 + DT_W'(1)) : dt6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else
        begin
            v7_reg <= rd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vm7_reg <= v_quo[30:0];
        r7_reg  <= r_quo;
        pv7_reg <= 65'(vmag) * 65'(dmag6);
        dt7_reg <= dt6;
        e7_reg  <= e6;
    end

    // stage 8: combine, saturate, drive result
    localparam logic signed [WORD_W-1:0] VEL_ONE = WORD_W'(1) << (WORD_W - 2);
    localparam logic signed [37:0] POS_MAX = 38'((64'd1 << (WORD_W - 1)) - 64'd1);
    localparam logic signed [37:0] POS_MIN = -POS_MAX - 38'sd1;

    logic [65:0]              pv_round;
    logic [35:0]              term;
    logic                     term_neg;
    logic signed [37:0]       base;
    logic signed [37:0]       pos_full;
    logic signed [WORD_W-1:0] pos_sat;
    logic                     pos_ovf;
    logic signed [WORD_W-1:0] vel;
    logic                     vel_ovf;
    logic signed [37:0]       h_full;
    logic signed [37:0]       h_lim;
    logic signed [WORD_W-1:0] h_sat;
    logic                     h_ovf;
    logic                     beyond;
    logic                     dt_neg;
    owe_result_t              result_next;
    owe_result_t              result_reg;
    logic                     done_reg;

    always_comb
    begin
        dt_neg   = dt7_reg[DT_W-1];
        pv_round = 66'(pv7_reg) + (66'd1 << 29);
        base     = 38'(intercept_reg);
        if (accelerated)
        begin
            term     = 36'(r7_reg);
            term_neg = accel_reg[WORD_W-1];
        end
        else
        begin
            term     = pv_round[65:30];
            term_neg = velocity_reg[WORD_W-1] ^ dt_neg;
        end
        pos_full = term_neg ? base - $signed(38'(term)) : base + $signed(38'(term));
        pos_ovf  = (pos_full > POS_MAX) || (pos_full < POS_MIN);
        if (pos_full > POS_MAX)
        begin
            pos_sat = POS_MAX[WORD_W-1:0];
        end
        else if (pos_full < POS_MIN)
        begin
            pos_sat = POS_MIN[WORD_W-1:0];
        end
        else
        begin
            pos_sat = pos_full[WORD_W-1:0];
        end

        vel_ovf = 1'b0;
        if (accelerated)
        begin
            vel = (accel_reg[WORD_W-1] ^ dt_neg) ? -$signed(WORD_W'(vm7_reg))
                                                 : $signed(WORD_W'(vm7_reg));
        end
        else if (velocity_reg > VEL_ONE)
        begin
            vel     = VEL_ONE;
            vel_ovf = 1'b1;
        end
        else if (velocity_reg < -VEL_ONE)
        begin
            vel     = -VEL_ONE;
            vel_ovf = 1'b1;
        end
        else
        begin
            vel = velocity_reg;
        end

        h_full = base - $signed(38'(inv_quo)) - 38'(dt7_reg);
        h_lim  = h_full - $signed(38'(tolerance_reg));
        beyond = horizon_on && (38'(e7_reg) < h_lim);
        h_ovf  = (h_full > POS_MAX) || (h_full < POS_MIN);
        if (h_full > POS_MAX)
        begin
            h_sat = POS_MAX[WORD_W-1:0];
        end
        else if (h_full < POS_MIN)
        begin
            h_sat = POS_MIN[WORD_W-1:0];
        end
        else
        begin
            h_sat = h_full[WORD_W-1:0];
        end

        result_next.observer_position = pos_sat;
        result_next.observer_velocity = vel;
        result_next.horizon_valid     = horizon_on;
        result_next.horizon_position  = horizon_on ? h_sat : '0;
        result_next.beyond_horizon    = beyond;
        result_next.overflow_flag     = pos_ovf || vel_ovf || (horizon_on && h_ovf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/owe_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a side tag along with each operand pair. No package dependencies.
// The quotient must fit in QW bits.
`default_nettype none

module owe_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QW = 34,
    parameter int TW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [TW-1:0] in_tag,
    output logic               out_valid,
    output logic [QW-1:0]      out_quo,
    output logic [TW-1:0]      out_tag
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic          valid_reg [QW];
    logic [NW-1:0] rem_reg   [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [QW-1:0] quo_reg   [QW];
    logic [TW-1:0] tag_reg   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic          prev_valid;
        logic [NW-1:0] prev_rem;
        logic [DW-1:0] prev_den;
        logic [QW-1:0] prev_quo;
        logic [TW-1:0] prev_tag;
        logic [CW-1:0] trial;
        logic [CW-1:0] diff;
        logic          take;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = in_num;
            assign prev_den   = in_den;
            assign prev_quo   = '0;
            assign prev_tag   = in_tag;
        end
        else begin : g_next
            assign prev_valid = valid_reg[k-1];
            assign prev_rem   = rem_reg[k-1];
            assign prev_den   = den_reg[k-1];
            assign prev_quo   = quo_reg[k-1];
            assign prev_tag   = tag_reg[k-1];
        end

        assign trial    = CW'(prev_den) << B;
        assign take     = CW'(prev_rem) >= trial;
        assign diff     = CW'(prev_rem) - trial;
        assign rem_next = take ? diff[NW-1:0] : prev_rem;
        assign quo_next = (prev_quo << 1) | QW'(take);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            den_reg[k] <= prev_den;
            quo_reg[k] <= quo_next;
            tag_reg[k] <= prev_tag;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

`default_nettype wire

>>> rtl/owe_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Gives floor(sqrt(x)) and carries a side tag. No package dependencies.
`default_nettype none

module owe_sqrt #(
    parameter int RW = 64,
    parameter int TW = 1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [2*RW-1:0] in_x,
    input  wire logic [TW-1:0]   in_tag,
    output logic                 out_valid,
    output logic [RW-1:0]        out_root,
    output logic [TW-1:0]        out_tag
);

    localparam int XW = 2 * RW;

    logic          valid_reg [RW];
    logic [XW-1:0] rem_reg   [RW];
    logic [RW-1:0] root_reg  [RW];
    logic [TW-1:0] tag_reg   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic          prev_valid;
        logic [XW-1:0] prev_rem;
        logic [RW-1:0] prev_root;
        logic [TW-1:0] prev_tag;
        logic [XW-1:0] trial;
        logic          take;
        logic [XW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (k == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = in_x;
            assign prev_root  = '0;
            assign prev_tag   = in_tag;
        end
        else begin : g_next
            assign prev_valid = valid_reg[k-1];
            assign prev_rem   = rem_reg[k-1];
            assign prev_root  = root_reg[k-1];
            assign prev_tag   = tag_reg[k-1];
        end

        assign trial     = (XW'(prev_root) << (B + 1)) | (XW'(1) << (2 * B));
        assign take      = prev_rem >= trial;
        assign rem_next  = take ? prev_rem - trial : prev_rem;
        assign root_next = take ? (prev_root | (RW'(1) << B)) : prev_root;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            tag_reg[k]  <= prev_tag;
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_tag   = tag_reg[RW-1];

endmodule

`default_nettype wire

>>> bench/tb_observer_worldline_evaluator.sv
// Self-checking bench for observer_worldline_evaluator: a queue-fed driver, a result monitor
// and an in-bench predictor of inertial and hyperbolic motion and the Rindler horizon.
// Depends on owe_pkg and the block's RTL.
module tb_observer_worldline_evaluator;
    import owe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 170;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic               mode;
        logic signed [31:0] accel;
        logic signed [31:0] vel;
        logic signed [31:0] x0;
        logic signed [31:0] t0;
        logic [15:0]        tol;
    } motion_cfg_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    owe_item_t            item;
    logic                 done;
    owe_result_t          result;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [WORD_W-1:0]    wr_data;

    motion_cfg_t cfg;
    owe_item_t   pending_items[$];
    owe_result_t expected_results[$];
    int          idle_pct;
    int          n_items;
    int          n_results;
    int          n_errors;
    int          n_cycles;
    logic        took;

    observer_worldline_evaluator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] mag64(logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    function automatic logic signed [63:0] sat32(logic signed [63:0] v, ref logic ovf);
        if (v > 64'sd2147483647)
        begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] offset_pos(logic signed [63:0] base, logic neg,
                                                      logic [63:0] m, ref logic ovf);
        logic signed [63:0] t;
        if (m > (64'd1 << 62))
            m = 64'd1 << 62;
        t = m;
        return sat32(neg ? base - t : base + t, ovf);
    endfunction

    function automatic logic [63:0] isqrt128(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= x)
                r = c;
        end
        return r;
    endfunction

    function automatic owe_result_t predict_worldline(owe_item_t it);
        owe_result_t        res;
        logic signed [63:0] dt;
        logic signed [63:0] e;
        logic signed [63:0] pos;
        logic signed [63:0] vel;
        logic signed [63:0] h;
        logic [63:0]        amag;
        logic [63:0]        s;
        logic [63:0]        g;
        logic [63:0]        vm;
        logic [63:0]        den;
        logic [63:0]        q;
        logic [63:0]        r;
        logic [63:0]        inv;
        logic [127:0]       s2;
        logic [127:0]       quot;
        logic               acc;
        logic               ovf;
        logic               neg;
        logic               hvalid;
        logic               beyond;
        dt = 64'(it.coordinate_time) - 64'(cfg.t0);
        e = 64'(it.event_position);
        amag = mag64(64'(cfg.accel));
        acc = cfg.mode && amag > {48'd0, cfg.tol};
        ovf = 1'b0;
        beyond = 1'b0;
        h = 0;
        if (!acc)
        begin
            r = (mag64(64'(cfg.vel)) * mag64(dt) + (64'd1 << 29)) >> 30;
            neg = (cfg.vel < 0) != (dt < 0);
            pos = offset_pos(64'(cfg.x0), neg, r, ovf);
            vel = 64'(cfg.vel);
            if (vel > (64'sd1 <<< 30))
            begin
                vel = 64'sd1 <<< 30;
                ovf = 1'b1;
            end
            if (vel < -(64'sd1 <<< 30))
            begin
                vel = -(64'sd1 <<< 30);
                ovf = 1'b1;
            end
        end
        else
        begin
            s = amag * mag64(dt);
            s2 = {64'd0, s} * {64'd0, s};
            g = isqrt128(s2 + (128'd1 << 64));
            quot = (({64'd0, s} << 30) + {64'd0, g >> 1}) / {64'd0, g};
            vm = quot[63:0];
            den = g + (64'd1 << 32);
            quot = (s2 + {64'd0, den >> 1}) / {64'd0, den};
            q = quot[63:0];
            r = (q + (amag >> 1)) / amag;
            neg = (cfg.accel < 0) != (dt < 0);
            vel = neg ? -$signed(vm) : $signed(vm);
            pos = offset_pos(64'(cfg.x0), cfg.accel < 0, r, ovf);
        end
        hvalid = acc && 64'(cfg.accel) > $signed({48'd0, cfg.tol});
        if (hvalid)
        begin
            inv = ((64'd1 << 32) + (amag >> 1)) / amag;
            h = 64'(cfg.x0) - $signed(inv) - dt;
            beyond = e < h - $signed({48'd0, cfg.tol});
            h = sat32(h, ovf);
        end
        res.observer_position = pos[31:0];
        res.observer_velocity = vel[31:0];
        res.horizon_valid = hvalid;
        res.horizon_position = h[31:0];
        res.beyond_horizon = beyond;
        res.overflow_flag = ovf;
        return res;
    endfunction

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        owe_result_t want;
        took <= start && !busy;
        if (rst_n && wr_en)
        begin
            case (wr_index)
                REG_MODE:      cfg.mode = wr_data[0];
                REG_ACCEL:     cfg.accel = wr_data;
                REG_VELOCITY:  cfg.vel = wr_data;
                REG_INTERCEPT: cfg.x0 = wr_data;
                REG_REF_TIME:  cfg.t0 = wr_data;
                REG_TOLERANCE: cfg.tol = wr_data[TOL_W-1:0];
                default:       ;
            endcase
        end
        if (rst_n && done)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                $error("result with no pending expectation");
                n_errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.observer_position !== want.observer_position)
                begin
                    $error("observer_position expected %0d got %0d",
                           want.observer_position, result.observer_position);
                    n_errors++;
                end
                if (result.observer_velocity !== want.observer_velocity)
                begin
                    $error("observer_velocity expected %0d got %0d",
                           want.observer_velocity, result.observer_velocity);
                    n_errors++;
                end
                if (result.horizon_valid !== want.horizon_valid)
                begin
                    $error("horizon_valid expected %0d got %0d",
                           want.horizon_valid, result.horizon_valid);
                    n_errors++;
                end
                if (result.horizon_position !== want.horizon_position)
                begin
                    $error("horizon_position expected %0d got %0d",
                           want.horizon_position, result.horizon_position);
                    n_errors++;
                end
                if (result.beyond_horizon !== want.beyond_horizon)
                begin
                    $error("beyond_horizon expected %0d got %0d",
                           want.beyond_horizon, result.beyond_horizon);
                    n_errors++;
                end
                if (result.overflow_flag !== want.overflow_flag)
                begin
                    $error("overflow_flag expected %0d got %0d",
                           want.overflow_flag, result.overflow_flag);
                    n_errors++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            expected_results.push_back(predict_worldline(item));
            n_items++;
        end
    end

    always @(negedge clk)
    begin
        logic      nxt_start;
        owe_item_t nxt_item;
        nxt_start = start;
        nxt_item = item;
        if (!rst_n)
            nxt_start = 1'b0;
        else if (!start || took)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt_start = 1'b1;
                nxt_item = pending_items.pop_front();
            end
            else
                nxt_start = 1'b0;
        end
        start <= nxt_start;
        item <= nxt_item;
    end

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic load_motion(logic mode, logic [31:0] a, logic [31:0] v, logic [31:0] x0,
                               logic [31:0] t0, logic [15:0] tol);
        write_reg(REG_MODE, {31'd0, mode});
        write_reg(REG_ACCEL, a);
        write_reg(REG_VELOCITY, v);
        write_reg(REG_INTERCEPT, x0);
        write_reg(REG_REF_TIME, t0);
        write_reg(REG_TOLERANCE, {16'd0, tol});
        write_reg(3'd7, $urandom);
    endtask

    task automatic drain;
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (start || expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    function automatic owe_item_t rand_event(logic [31:0] t0);
        owe_item_t it;
        int        k;
        k = $urandom_range(3);
        it.coordinate_time = $urandom;
        it.event_position = $urandom;
        if (k == 1)
            it.coordinate_time = t0 + $signed({{12{1'b0}}, 20'($urandom)}) - 32'sd524288;
        else if (k == 2)
        begin
            it.coordinate_time = t0 + $signed(32'($signed(16'($urandom))));
            it.event_position = $signed(32'($signed(24'($urandom))));
        end
        return it;
    endfunction

    task automatic queue_event(logic [31:0] t, logic [31:0] e);
        owe_item_t it;
        it.coordinate_time = t;
        it.event_position = e;
        pending_items.push_back(it);
    endtask

    task automatic directed_events;
        queue_event(32'h0000_0000, 32'h0000_0000);
        queue_event(32'h7fff_ffff, 32'h8000_0000);
        queue_event(32'h8000_0000, 32'h7fff_ffff);
        queue_event(32'h0001_0000, 32'hffff_0000);
        queue_event(32'hffff_0000, 32'h0001_0000);
        queue_event(32'h0000_0001, 32'hffff_ffff);
        queue_event(32'h0010_0000, 32'hfff0_0000);
        queue_event(32'hfff0_0000, 32'h0010_0000);
    endtask

    initial
    begin
        int phase_idle[4];
        phase_idle = '{0, 76, 76, 22};
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        idle_pct = 0;
        n_items = 0;
        n_results = 0;
        n_errors = 0;
        n_cycles = 0;
        cfg = '{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'd1};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_events();
        drain();
        load_motion(1'b0, 32'h0, 32'h4000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'd0);
        directed_events();
        drain();
        load_motion(1'b0, 32'h0, 32'hc000_0000, 32'h8000_0000, 32'h7fff_ffff, 16'hffff);
        directed_events();
        drain();
        load_motion(1'b0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0, 16'd1);
        directed_events();
        drain();
        load_motion(1'b1, 32'h0001_0000, 32'h8000_0000, 32'h0, 32'h0, 16'h0001);
        directed_events();
        drain();
        load_motion(1'b1, 32'h0000_0100, 32'h0, 32'h0, 32'h0, 16'h0100);
        directed_events();
        drain();
        load_motion(1'b1, 32'hffff_0000, 32'h0, 32'h7fff_ffff, 32'h0, 16'h0);
        directed_events();
        drain();
        load_motion(1'b1, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0, 16'hffff);
        directed_events();
        drain();
        load_motion(1'b1, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 16'hffff);
        directed_events();
        drain();
        load_motion(1'b1, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 16'h0);
        directed_events();
        drain();

        for (int p = 0; p < 16; p++)
        begin
            logic [31:0] a;
            logic [31:0] v;
            logic [31:0] t0;
            a = $urandom;
            case ($urandom_range(3))
                0: a = $signed(32'($signed(18'($urandom))));
                1: a = $signed(32'($signed(22'($urandom))));
                default: ;
            endcase
            v = $signed(32'($signed(31'($urandom))));
            if ($urandom_range(7) == 0)
                v = $urandom;
            t0 = $urandom;
            load_motion(p % 4 != 0, a, v, $urandom, t0,
                        ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(255)));
            idle_pct = phase_idle[p % 4];
            repeat (110)
                pending_items.push_back(rand_event(t0));
            drain();
        end

        $display("Covered %0d transfers and %0d results over inertial, hyperbolic and horizon",
                 n_items, n_results);
        $display("settings, with register extremes and several idle patterns.");
        if (n_errors == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> files.f
rtl/owe_pkg.sv
rtl/owe_div.sv
rtl/owe_sqrt.sv
rtl/observer_worldline_evaluator.sv
bench/tb_observer_worldline_evaluator.sv
